### hw/rtl/binary_max_heap_queue_assert.svh
// Assertion macros for the heap queue checker.
// Depends on nothing; included by the checker file.
`ifndef BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
// Check a property on every rising clock edge outside reset.
`define BMHQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property including reset cycles.
`define BMHQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### hw/rtl/bmhq_pkg.sv
// Shared types and constants for the binary max-heap queue.
// No dependencies.
`timescale 1ns / 1ps
package bmhq_pkg;
   localparam int PRIO_W = 16;
   localparam int TAG_W  = 16;
   localparam int CNT_W  = 7;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]         tag;
   } entry_type;

   typedef struct packed {
      op_type                   operation;
      logic signed [PRIO_W-1:0] priority_req;
      logic [TAG_W-1:0]         payload_tag;
   } req_type;

   typedef struct packed {
      logic                     accepted;
      logic [CNT_W-1:0]         entry_total;
      logic                     top_valid;
      logic signed [PRIO_W-1:0] top_priority;
      logic [TAG_W-1:0]         top_payload;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_DN_ROOT,
      ST_TOP_RD,
      ST_TOP_WAIT,
      ST_DONE
   } state_type;
endpackage

### hw/rtl/bmhq_if.sv
// Valid/ready channel carrying one packed payload beat.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
interface bmhq_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/bmhq_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write or read one address per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/bmhq_ctrl.sv
// Sift sequencer: walks the heap one level at a time through the RAM port.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps
module bmhq_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  bmhq_pkg::req_type                 req,
   output logic                              busy,
   output logic                              done,
   output bmhq_pkg::rsp_type                 rsp,
   output logic                              ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]          ram_addr,
   output bmhq_pkg::entry_type               ram_wr_data,
   input  bmhq_pkg::entry_type               ram_rd_data
);
   import bmhq_pkg::*;
   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   state_type state_ff, state_in;
   logic [NW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] big_ff, big_in;
   entry_type     cur_ff, cur_in;
   entry_type     left_ff, left_in;
   entry_type     best_ff, best_in;
   logic          ok_ff, ok_in;
   rsp_type       rsp_ff, rsp_in;

   // Child indexes of the current position, wide enough to compare with count.
   logic [AW+1:0] left_idx, right_idx;
   logic [AW-1:0] parent_idx;
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = {pos_ff, 1'b0} + (AW+2)'(2);
   assign parent_idx = (pos_ff - AW'(1)) >> 1;

   // Advance the sequencer and carry the working entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff  <= pos_in;
      big_ff  <= big_in;
      cur_ff  <= cur_in;
      left_ff <= left_in;
      best_ff <= best_in;
      ok_ff   <= ok_in;
      rsp_ff  <= rsp_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req.operation == OP_INSERT) begin
                  if (count_ff == NW'(DEPTH)) state_in = ST_TOP_RD;
                  else if (count_ff == '0) state_in = ST_TOP_RD;
                  else state_in = ST_UP_RD;
               end else begin
                  if (count_ff == '0) state_in = ST_TOP_RD;
                  else if (count_ff == NW'(1)) state_in = ST_TOP_RD;
                  else state_in = ST_DN_ROOT;
               end
            end
         end
         ST_UP_RD:    state_in = ST_UP_CMP;
         ST_UP_CMP: begin
            if (ram_rd_data.prio <= cur_ff.prio && parent_idx != '0) state_in = ST_UP_RD;
            else state_in = ST_TOP_RD;
         end
         ST_DN_ROOT: state_in = ST_DN_RDL;
         ST_DN_RDL: begin
            if (left_idx >= (AW+2)'(count_ff)) state_in = ST_TOP_RD;
            else state_in = ST_DN_RDR;
         end
         ST_DN_RDR: state_in = ST_DN_CMP;
         ST_DN_CMP: begin
            if (cur_ff.prio < best_in.prio) state_in = ST_DN_RDL;
            else state_in = ST_TOP_RD;
         end
         ST_TOP_RD:   state_in = ST_TOP_WAIT;
         ST_TOP_WAIT: state_in = ST_DONE;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and RAM port.
   always_comb begin
      count_in    = count_ff;
      pos_in      = pos_ff;
      big_in      = big_ff;
      cur_in      = cur_ff;
      left_in     = left_ff;
      best_in     = best_ff;
      ok_in       = ok_ff;
      rsp_in      = rsp_ff;
      ram_wr_en   = 1'b0;
      ram_addr    = pos_ff;
      ram_wr_data = cur_ff;
      case (state_ff)
         ST_IDLE: begin
            ok_in = 1'b0;
            if (start) begin
               cur_in = '{prio: req.priority_req, tag: req.payload_tag};
               if (req.operation == OP_INSERT) begin
                  if (count_ff != NW'(DEPTH)) begin
                     ok_in     = 1'b1;
                     pos_in    = AW'(count_ff);
                     ram_addr  = AW'(count_ff);
                     ram_wr_en = 1'b1;
                     ram_wr_data = cur_in;
                     count_in  = count_ff + NW'(1);
                  end
               end else if (count_ff != '0) begin
                  ok_in    = 1'b1;
                  ram_addr = AW'(count_ff - NW'(1));
                  count_in = count_ff - NW'(1);
                  pos_in   = '0;
               end
            end
         end
         ST_UP_RD: begin
            ram_addr = parent_idx;
         end
         ST_UP_CMP: begin
            // Swap with the parent unless the entry is strictly smaller.
            if (!(cur_ff.prio < ram_rd_data.prio)) begin
               ram_wr_en   = 1'b1;
               ram_addr    = pos_ff;
               ram_wr_data = ram_rd_data;
               pos_in      = parent_idx;
               if (parent_idx == '0 || ram_rd_data.prio > cur_ff.prio) begin
                  // final position reached next; written in ST_TOP_RD path below
               end
            end
         end
         ST_DN_ROOT: begin
            // Last entry read arrives; store it at the root.
            cur_in      = ram_rd_data;
            ram_wr_en   = 1'b1;
            ram_addr    = '0;
            ram_wr_data = ram_rd_data;
         end
         ST_DN_RDL: begin
            ram_addr = left_idx[AW-1:0];
         end
         ST_DN_RDR: begin
            left_in  = ram_rd_data;
            ram_addr = right_idx[AW-1:0];
         end
         ST_DN_CMP: begin
            best_in = left_ff;
            big_in  = left_idx[AW-1:0];
            if (right_idx < (AW+2)'(count_ff) && ram_rd_data.prio > left_ff.prio) begin
               best_in = ram_rd_data;
               big_in  = right_idx[AW-1:0];
            end
            // Swap the current entry with the larger child when strictly smaller.
            if (cur_ff.prio < best_in.prio) begin
               ram_wr_en   = 1'b1;
               ram_addr    = pos_ff;
               ram_wr_data = best_in;
               pos_in      = big_in;
            end
         end
         ST_TOP_RD: begin
            // Place the sifted entry at its final spot, then read the root.
            if (ok_ff) begin
               ram_wr_en   = 1'b1;
               ram_addr    = pos_ff;
               ram_wr_data = cur_ff;
            end
         end
         ST_TOP_WAIT: begin
            ram_addr = '0;
         end
         ST_DONE: begin
            rsp_in.accepted    = ok_ff;
            rsp_in.entry_total = CNT_W'(count_ff);
            rsp_in.top_valid   = (count_ff != '0);
            rsp_in.top_priority = (count_ff != '0) ? ram_rd_data.prio : '0;
            rsp_in.top_payload  = (count_ff != '0) ? ram_rd_data.tag : '0;
         end
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp  = rsp_ff;

   // Result register is loaded in ST_DONE; done pulses in the cycle after.
   logic done_ff;
   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else done_ff <= (state_ff == ST_DONE);
   end
   assign done = done_ff;
endmodule

### hw/rtl/binary_max_heap_queue.sv
// Binary max-heap priority queue top level: channels, result buffer, RAM.
// Depends on bmhq_pkg, bmhq_if, bmhq_ram and bmhq_ctrl.
//
// One request beat in, one response beat out. The heap lives in a single-port
// RAM of DEPTH 32-bit entries. Each level going up takes a parent read, then a
// compare and swap; each level going down takes a left read, a right read, then
// a compare and swap. The entry is then placed and the root read back, and the
// response is registered. A refused request skips the sift. A new request is
// taken only once the sequencer is idle, no response is being loaded, and the
// response register is empty or draining in that cycle.
`timescale 1ns / 1ps
module binary_max_heap_queue #(
   parameter int DEPTH = 64
) (
   input logic clock,
   input logic reset,
   bmhq_if.sink   req_chan,
   bmhq_if.source rsp_chan
);
   import bmhq_pkg::*;
   localparam int AW = $clog2(DEPTH);

   logic      busy, done, start;
   rsp_type   rsp_w;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff;
   logic      ram_wr_en;
   logic [AW-1:0] ram_addr;
   entry_type ram_wr_data, ram_rd_data;

   // Accept a request when the sequencer is idle, no response is being loaded,
   // and the output slot is free or draining this cycle.
   assign req_chan.ready = !busy && !done && (!rsp_valid_ff || rsp_chan.ready);
   assign start = req_chan.valid && req_chan.ready;

   bmhq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req(req_chan.payload),
      .busy(busy), .done(done), .rsp(rsp_w),
      .ram_wr_en(ram_wr_en), .ram_addr(ram_addr),
      .ram_wr_data(ram_wr_data), .ram_rd_data(ram_rd_data)
   );

   bmhq_ram #(.WIDTH($bits(entry_type)), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_wr_en), .addr(ram_addr),
      .wr_data(ram_wr_data), .rd_data(ram_rd_data)
   );

   // Hold the response until the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;
      if (done) rsp_valid_in = 1'b1;
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      if (done) rsp_data_ff <= rsp_w;
   end
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;
endmodule

### hw/rtl/bmhq_checker.sv
// Port-level checker for the heap queue, bound to the top level.
// Depends on bmhq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "binary_max_heap_queue_assert.svh"
module bmhq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bmhq_pkg::rsp_type rsp_payload
);
   import bmhq_pkg::*;
   `BMHQ_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "response dropped or changed while stalled")
   `BMHQ_ASSERT(a_top_empty, clock, reset, rsp_valid && !rsp_payload.top_valid |-> rsp_payload.entry_total == '0 && rsp_payload.top_priority == '0, "empty heap shows a top entry")
   `BMHQ_ASSERT(a_top_count, clock, reset, rsp_valid |-> rsp_payload.top_valid == (rsp_payload.entry_total != '0), "top valid disagrees with count")
   `BMHQ_ASSERT(a_no_back, clock, reset, req_valid && req_ready |=> !req_ready, "second request taken before the first finished")
   `BMHQ_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "response valid after reset")
endmodule

bind binary_max_heap_queue bmhq_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_chan.valid), .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
   .rsp_payload(rsp_chan.payload)
);

### tb/tb.sv
// Self-checking testbench for the binary max-heap priority queue.
// Depends on bmhq_pkg, bmhq_if and binary_max_heap_queue; predicts every response.
`timescale 1ns / 1ps
module tb;
   import bmhq_pkg::*;

   localparam int HEAP_DEPTH = 64;
   localparam int WATCHDOG_LIMIT = 20000;

   // Heap predictor plus a store of expected response beats.
   class heap_scoreboard;
      entry_type heap_entries [HEAP_DEPTH];
      int        entry_count;
      rsp_type   expected_rsps [$];
      int        mismatch_count;

      function void swap_entries(int a, int b);
         entry_type t;
         t = heap_entries[a];
         heap_entries[a] = heap_entries[b];
         heap_entries[b] = t;
      endfunction

      // Apply one accepted request and queue the predicted response.
      function void note_request(req_type req);
         rsp_type rsp;
         bit      done;
         int      pos;
         int      parent;
         int      left;
         int      big;
         done = 0;
         if (req.operation == OP_INSERT) begin
            if (entry_count < HEAP_DEPTH) begin
               done = 1;
               pos = entry_count;
               heap_entries[pos].prio = req.priority_req;
               heap_entries[pos].tag = req.payload_tag;
               // Sift up: equal priorities move above their parent.
               while (pos > 0) begin
                  parent = (pos - 1) / 2;
                  if (heap_entries[pos].prio < heap_entries[parent].prio) break;
                  swap_entries(pos, parent);
                  pos = parent;
               end
               entry_count++;
            end
         end else if (entry_count > 0) begin
            done = 1;
            heap_entries[0] = heap_entries[entry_count - 1];
            entry_count--;
            pos = 0;
            // Sift down: right child only when strictly larger.
            forever begin
               left = 2 * pos + 1;
               if (left >= entry_count) break;
               big = left;
               if (left + 1 < entry_count &&
                   heap_entries[left + 1].prio > heap_entries[left].prio)
                  big = left + 1;
               if (!(heap_entries[pos].prio < heap_entries[big].prio)) break;
               swap_entries(pos, big);
               pos = big;
            end
         end
         rsp = '0;
         rsp.accepted = done;
         rsp.entry_total = entry_count[CNT_W-1:0];
         if (entry_count > 0) begin
            rsp.top_valid = 1'b1;
            rsp.top_priority = heap_entries[0].prio;
            rsp.top_payload = heap_entries[0].tag;
         end
         expected_rsps.push_back(rsp);
      endfunction

      function void report_mismatch(string what);
         $display("%0t mismatch: %s", $realtime, what);
         mismatch_count++;
      endfunction

      // Compare one response beat with the oldest expectation.
      function void check_response(rsp_type got);
         rsp_type exp;
         if (expected_rsps.size() == 0) begin
            report_mismatch("response beat with nothing expected");
            return;
         end
         exp = expected_rsps.pop_front();
         if (got.accepted !== exp.accepted)
            report_mismatch($sformatf("accepted %b exp %b", got.accepted, exp.accepted));
         if (got.entry_total !== exp.entry_total)
            report_mismatch($sformatf("entry_total %0d exp %0d",
                                      got.entry_total, exp.entry_total));
         if (got.top_valid !== exp.top_valid)
            report_mismatch($sformatf("top_valid %b exp %b", got.top_valid, exp.top_valid));
         if (got.top_priority !== exp.top_priority)
            report_mismatch($sformatf("top_priority %0d exp %0d",
                                      got.top_priority, exp.top_priority));
         if (got.top_payload !== exp.top_payload)
            report_mismatch($sformatf("top_payload %h exp %h",
                                      got.top_payload, exp.top_payload));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bmhq_if #(.PAYLOAD_TYPE(req_type)) req_chan ();
   bmhq_if #(.PAYLOAD_TYPE(rsp_type)) rsp_chan ();

   binary_max_heap_queue #(.DEPTH(HEAP_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #10 clock = ~clock;

   heap_scoreboard board = new();
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  recv_hold = 0;
   int  stall_cycles = 0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
   end

   // Note request beats and check response beats at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) board.note_request(req_chan.payload);
         if (rsp_chan.valid && rsp_chan.ready) board.check_response(rsp_chan.payload);
      end
   end

   // Drive ready with random stalls, or hold it low during a long hold-off.
   always @(posedge clock) begin
      if (reset || recv_hold) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Count cycles without any beat; give up at the limit.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // Offer one request beat, with random idle cycles first, and wait for it.
   // Valid stays high after the beat until the next call or a drain drops it.
   task automatic send_request(op_type op, logic signed [PRIO_W-1:0] prio,
                               logic [TAG_W-1:0] tag);
      req_type req;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req.operation = op;
      req.priority_req = prio;
      req.payload_tag = tag;
      req_chan.valid <= 1'b1;
      req_chan.payload <= req;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_random(int insert_pct);
      op_type                   op;
      logic signed [PRIO_W-1:0] prio;
      op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      // Mostly a narrow band so that equal priorities show up often.
      if ($urandom_range(3) == 0) prio = PRIO_W'($urandom());
      else prio = $signed(16'($urandom_range(8))) - 16'sd4;
      send_request(op, prio, TAG_W'($urandom()));
   endtask

   // Drop valid and wait until every expected response has arrived.
   task automatic drain;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.expected_rsps.size() != 0) @(posedge clock);
   endtask

   initial begin
      int phase;
      int i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: remove when empty, field extremes, equal priorities.
      send_request(OP_REMOVE, 16'sh7fff, 16'hffff);
      send_request(OP_INSERT, 16'sh8000, 16'h0000);
      send_request(OP_INSERT, 16'sd32767, 16'hffff);
      send_request(OP_INSERT, 16'sd0, 16'h5555);
      send_request(OP_INSERT, 16'sd32767, 16'haaaa);
      send_request(OP_INSERT, 16'sd0, 16'h0001);
      for (i = 0; i < 6; i++) send_request(OP_REMOVE, 16'sd0, 16'h0000);
      send_request(OP_INSERT, -16'sd1, 16'h8000);
      send_request(OP_REMOVE, 16'sd5, 16'h1234);

      // Fill to capacity while the receiver holds off, then refuse one insert.
      recv_hold = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            recv_hold = 0;
         end
         for (i = 0; i < HEAP_DEPTH; i++) send_random(100);
      join
      send_request(OP_INSERT, 16'sd1, 16'h0f0f);
      drain();
      // Empty it again after a full pause.
      for (i = 0; i < HEAP_DEPTH; i++) send_random(0);

      // Random phases with different idle mixes.
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 58 : 0;
         recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 19 : 0;
         for (i = 0; i < 160; i++) begin
            // Drift between fill and drain to reach both ends.
            send_random(((i / 40) % 2 == 0) ? 75 : 30);
         end
      end
      drain();
      repeat (100) @(posedge clock);
      if (board.mismatch_count == 0 && board.expected_rsps.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
